[hdl/ring_buffer_delimited_frame_extract_assert.svh]
// ----------------------------------------------------------------------------
// ring_buffer_delimited_frame_extract assertion macros
// shared assertion forms for the frame extractor checker
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_DELIMITED_FRAME_EXTRACT_ASSERT_SVH
`define RING_BUFFER_DELIMITED_FRAME_EXTRACT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RBDFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RBDFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rbdfe_pkg.sv]
// ----------------------------------------------------------------------------
// rbdfe_pkg
// shared types, sizes and helpers of the delimited frame extractor
// ----------------------------------------------------------------------------
`default_nettype none

package rbdfe_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int BYTE_W = 8;
	localparam int ACT_W  = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_PEEK  = 2'd1,
		ACT_POP   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_MISS
	} state_t;

	// ring position increment with wrap at the store depth
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] p);
		if (p == IDX_W'(DEPTH - 1)) begin
			return '0;
		end else begin
			return p + 1'b1;
		end
	endfunction

endpackage

`default_nettype wire

[hdl/rbdfe_ram.sv]
// ----------------------------------------------------------------------------
// rbdfe_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rbdfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[hdl/ring_buffer_delimited_frame_extract.sv]
// ----------------------------------------------------------------------------
// ring_buffer_delimited_frame_extract
// byte ring buffer that answers delimited frame peek and pop searches
// search: scans the stored bytes from the read position until a complete frame
//   closes or the write position is reached (at most DEPTH-1 bytes), then reads
//   and emits each frame byte, or a single not-found result; out stalls hold results
// throughput: writes back to back; a search stalls the input from its accept
//   until its last result is loaded into the output register
// reset: read and write positions go to zero, store contents stay undefined
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_delimited_frame_extract (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [rbdfe_pkg::ACT_W-1:0]   action,
	input  wire logic [rbdfe_pkg::BYTE_W-1:0]  data_byte,
	input  wire logic [rbdfe_pkg::BYTE_W-1:0]  start_char,
	input  wire logic [rbdfe_pkg::BYTE_W-1:0]  end_char,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [rbdfe_pkg::BYTE_W-1:0]  frame_byte,
	output logic                               found,
	output logic                               last
);

	import rbdfe_pkg::*;

	// sequencer state
	state_t state_q, state_nxt;

	// ring positions
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] wr_idx_q;

	// search context; position, delimiters and mode are captured when a peek or pop transaction is accepted
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  start_pos_q;
	logic [IDX_W-1:0]  end_pos_q;
	logic              started_q;
	logic              pop_q;
	logic [BYTE_W-1:0] sc_q;
	logic [BYTE_W-1:0] ec_q;

	// output register, parts the search engine from the output stall
	logic              out_valid_q;
	logic [BYTE_W-1:0] frame_byte_q;
	logic              found_q;
	logic              last_q;

	// ram ports
	logic              wr_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [BYTE_W-1:0] rd_data;

	// handshake and compare unit
	logic in_fire;
	logic is_write;
	logic is_search;
	logic slot_free;
	logic scan_empty;
	logic hit_start;
	logic hit_end;
	logic emit_last;

	// output register load
	logic              load_out;
	logic [BYTE_W-1:0] load_byte;
	logic              load_found;
	logic              load_last;

	rbdfe_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx_q),
		.wr_data (data_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign is_write  = (action == ACT_WRITE);
	assign is_search = (action == ACT_PEEK) || (action == ACT_POP);

	// the output slot can take a new result this cycle
	assign slot_free = !out_valid_q || !out_stall;

	// shared byte compare unit: the ram data always belongs to pos_q in scan
	assign scan_empty = (pos_q == wr_idx_q);
	assign hit_start  = !started_q && (rd_data == sc_q);
	assign hit_end    = (started_q || hit_start) && (rd_data == ec_q);
	assign emit_last  = (pos_q == end_pos_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && is_search) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// reached the write position without a complete frame
				if (scan_empty) begin
					state_nxt = ST_MISS;
				end else if (hit_end) begin
					state_nxt = ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: begin
				state_nxt = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (slot_free) begin
					state_nxt = emit_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			ST_MISS: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		wr_en      = 1'b0;
		rd_addr    = pos_q;
		load_out   = 1'b0;
		load_byte  = '0;
		load_found = 1'b0;
		load_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				wr_en   = in_fire && is_write;
				// prefetch the first byte of a search
				rd_addr = rd_idx_q;
			end
			ST_SCAN: begin
				// one byte per cycle: fetch the next while checking this one
				rd_addr = next_idx(pos_q);
			end
			ST_EMIT_RD: begin
				rd_addr = pos_q;
			end
			ST_EMIT_OUT: begin
				// address held so the read data stays put under stall
				rd_addr    = pos_q;
				load_out   = slot_free;
				load_byte  = rd_data;
				load_found = 1'b1;
				load_last  = emit_last;
			end
			ST_MISS: begin
				// single not-found result
				load_out   = slot_free;
				load_byte  = '0;
				load_found = 1'b0;
				load_last  = 1'b1;
			end
			default: begin
				rd_addr = pos_q;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;

			// write transaction: store and advance, overruns simply overwrite
			if (wr_en) begin
				wr_idx_q <= next_idx(wr_idx_q);
			end

			if (in_fire && is_search) begin
				started_q <= 1'b0;
			end else if (state_q == ST_SCAN && !scan_empty && hit_start) begin
				started_q <= 1'b1;
			end

			// a pop leaves the read position on the end delimiter
			if (state_q == ST_SCAN && !scan_empty && hit_end && pop_q) begin
				rd_idx_q <= pos_q;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		if (in_fire && is_search) begin
			pos_q <= rd_idx_q;
			sc_q  <= start_char;
			ec_q  <= end_char;
			pop_q <= (action == ACT_POP);
		end

		if (state_q == ST_SCAN && !scan_empty) begin
			if (hit_start) begin
				start_pos_q <= pos_q;
			end
			if (hit_end) begin
				end_pos_q <= pos_q;
				// rewind to the start delimiter for the copy pass
				pos_q     <= hit_start ? pos_q : start_pos_q;
			end else begin
				pos_q <= next_idx(pos_q);
			end
		end

		if (state_q == ST_EMIT_OUT && slot_free && !emit_last) begin
			pos_q <= next_idx(pos_q);
		end

		if (load_out) begin
			frame_byte_q <= load_byte;
			found_q      <= load_found;
			last_q       <= load_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign found      = found_q;
	assign last       = last_q;

endmodule

`default_nettype wire

[hdl/rbdfe_checker.sv]
// ----------------------------------------------------------------------------
// rbdfe_checker
// port level checks of the frame extractor, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ring_buffer_delimited_frame_extract_assert.svh"

module rbdfe_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic [rbdfe_pkg::ACT_W-1:0]   action,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [rbdfe_pkg::BYTE_W-1:0]  frame_byte,
	input wire logic                          found,
	input wire logic                          last
);

	import rbdfe_pkg::*;

	// held output transaction keeps its payload
	`RBDFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(frame_byte) && $stable(found) && $stable(last), "stalled result changed")

	// a miss is a single zero result that closes the search
	`RBDFE_ASSERT_NOW(a_miss_shape, out_valid && !found, last && (frame_byte == '0), "bad not-found result")

	// a search keeps the input side busy in the following cycle
	`RBDFE_ASSERT_NEXT(a_search_busy, in_valid && !in_stall && (action == ACT_PEEK || action == ACT_POP), in_stall, "search did not hold input")

	// a write leaves the input side free in the following cycle
	`RBDFE_ASSERT_NEXT(a_write_one, in_valid && !in_stall && action == ACT_WRITE, !in_stall, "write took more than one cycle")

endmodule

bind ring_buffer_delimited_frame_extract rbdfe_checker u_rbdfe_checker (.*);

`default_nettype wire
